FILE: sv/k_way_run_merger_macros.svh
// Assertion macros for the bound checker in kwrm_checker.sv.
`ifndef K_WAY_RUN_MERGER_MACROS_SVH
`define K_WAY_RUN_MERGER_MACROS_SVH

// Overlapping implication, checked on every rising clock edge outside reset.
`define KWRM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked on the next clock edge.
`define KWRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/kwrm_pkg.sv
`default_nettype none

package kwrm_pkg;

    localparam int DEPTH_DEF    = 1024;
    localparam int MAX_RUNS_DEF = 8;
    localparam int VAL_W        = 32;
    localparam int RL_W         = 11;
    localparam int OP_W         = 2;
    localparam int RL_MAX       = 2047;

    localparam logic [RL_W-1:0] RL_RESET = 11'd128;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_EMIT  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: sv/k_way_run_merger.sv
`default_nettype none

// K-way merger of sorted runs. Load words append signed values to an internal store of DEPTH
// entries; the store is read as sorted runs of run_length values laid end to end, and each emit
// word returns the smallest current run head, lowest run number first on ties, flagged with
// tlast on the final value and with tuser when nothing is left. Load and clear words leave the
// input ready for the next word. An emit walks the MAX_RUNS run heads through one comparator,
// one run per cycle behind a two-stage read of the head table and the element store, into the
// result register; the first emit after reset or a clear first writes the MAX_RUNS head
// pointers, one per cycle. The input side accepts a new word while a finished result still
// waits in the output register.
module k_way_run_merger #(
    parameter int DEPTH    = kwrm_pkg::DEPTH_DEF,
    parameter int MAX_RUNS = kwrm_pkg::MAX_RUNS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_wr_en,
    input  wire  [kwrm_pkg::RL_W-1:0]    cfg_wr_data,  // run_length
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [kwrm_pkg::VAL_W-1:0]   s_tdata,      // element_value
    input  wire  [kwrm_pkg::OP_W-1:0]    s_tuser,      // opcode
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [kwrm_pkg::VAL_W-1:0]   m_tdata,      // merged_value
    output logic                         m_tlast,      // is_last
    output logic [0:0]                   m_tuser       // is_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int RI = $clog2(MAX_RUNS);
    localparam int HW = $clog2(MAX_RUNS * kwrm_pkg::RL_MAX + DEPTH + 2);

    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [RI-1:0] LAST_RUN = RI'(MAX_RUNS - 1);

    kwrm_pkg::state_t state_reg, state_next;

    logic [kwrm_pkg::RL_W-1:0]          rl_reg;
    logic [CW-1:0]                      count_reg;
    logic                               started_reg;

    logic signed [kwrm_pkg::VAL_W-1:0]  store [DEPTH];
    logic [HW-1:0]                      head_mem [MAX_RUNS];

    logic [RI-1:0]                      idx_reg;
    logic                               issue_reg;
    logic [HW-1:0]                      acc_reg;

    logic                               s1_valid_reg;
    logic                               s1_last_reg;
    logic [RI-1:0]                      s1_idx_reg;
    logic [HW-1:0]                      head_q_reg;

    logic                               s2_valid_reg;
    logic                               s2_last_reg;
    logic [RI-1:0]                      s2_idx_reg;
    logic                               s2_hit_reg;
    logic                               s2_next_ok_reg;
    logic [HW-1:0]                      s2_head_reg;
    logic signed [kwrm_pkg::VAL_W-1:0]  elem_q_reg;

    logic                               best_found_reg;
    logic                               best_two_reg;
    logic signed [kwrm_pkg::VAL_W-1:0]  best_val_reg;
    logic [RI-1:0]                      best_idx_reg;
    logic [HW-1:0]                      best_head_reg;
    logic                               best_next_ok_reg;

    logic                               m_valid_reg;
    logic [kwrm_pkg::VAL_W-1:0]         m_data_reg;
    logic                               m_last_reg;
    logic                               m_empty_reg;

    kwrm_pkg::op_t                      op;
    logic                               accept;
    logic                               load_ok;
    logic                               init_start;
    logic                               scan_start;
    logic                               out_load;
    logic [kwrm_pkg::RL_W-1:0]          rl_eff;
    logic [HW-1:0]                      rl_ext;
    logic [HW-1:0]                      count_ext;
    logic [HW-1:0]                      head_inc;
    logic                               s1_hit;
    logic                               s1_next_ok;
    logic                               take;

    assign op        = kwrm_pkg::op_t'(s_tuser);
    assign s_tready  = (state_reg == kwrm_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign load_ok   = accept && (op == kwrm_pkg::OP_LOAD) && !started_reg
                       && (count_reg < DEPTH_C);
    assign rl_eff    = (rl_reg == '0) ? kwrm_pkg::RL_W'(1) : rl_reg;
    assign rl_ext    = HW'(rl_eff);
    assign count_ext = HW'(count_reg);
    assign head_inc  = head_q_reg + HW'(1);

    assign s1_hit     = (head_q_reg < acc_reg) && (head_q_reg < count_ext);
    assign s1_next_ok = (head_inc < acc_reg) && (head_inc < count_ext);

    assign take = s2_valid_reg && s2_hit_reg && (!best_found_reg || (elem_q_reg < best_val_reg));

    always_comb
    begin
        state_next = state_reg;
        init_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            kwrm_pkg::ST_IDLE:
            begin
                if (accept && (op == kwrm_pkg::OP_EMIT))
                begin
                    if (started_reg)
                    begin
                        state_next = kwrm_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = kwrm_pkg::ST_INIT;
                        init_start = 1'b1;
                    end
                end
            end
            kwrm_pkg::ST_INIT:
            begin
                if (idx_reg == LAST_RUN)
                begin
                    state_next = kwrm_pkg::ST_SCAN;
                end
            end
            kwrm_pkg::ST_SCAN:
            begin
                if (s2_valid_reg && s2_last_reg)
                begin
                    state_next = kwrm_pkg::ST_DONE;
                end
            end
            kwrm_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = kwrm_pkg::ST_IDLE;
                    out_load   = 1'b1;
                end
            end
            default:
            begin
                state_next = kwrm_pkg::ST_IDLE;
            end
        endcase
        scan_start = (state_next == kwrm_pkg::ST_SCAN) && (state_reg != kwrm_pkg::ST_SCAN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= kwrm_pkg::ST_IDLE;
            rl_reg         <= kwrm_pkg::RL_RESET;
            count_reg      <= '0;
            started_reg    <= 1'b0;
            idx_reg        <= '0;
            issue_reg      <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            best_found_reg <= 1'b0;
            best_two_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                rl_reg <= cfg_wr_data;
            end
            if (load_ok)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (accept && (op == kwrm_pkg::OP_CLEAR))
            begin
                count_reg   <= '0;
                started_reg <= 1'b0;
            end
            if ((state_reg == kwrm_pkg::ST_INIT) && (idx_reg == LAST_RUN))
            begin
                started_reg <= 1'b1;
            end
            if (init_start || scan_start)
            begin
                idx_reg <= '0;
            end
            else if ((state_reg == kwrm_pkg::ST_INIT) || issue_reg)
            begin
                idx_reg <= idx_reg + RI'(1);
            end
            if (scan_start)
            begin
                issue_reg <= 1'b1;
            end
            else if (issue_reg && (idx_reg == LAST_RUN))
            begin
                issue_reg <= 1'b0;
            end
            s1_valid_reg <= issue_reg;
            s2_valid_reg <= s1_valid_reg;
            if (scan_start)
            begin
                best_found_reg <= 1'b0;
                best_two_reg   <= 1'b0;
            end
            else
            begin
                if (take)
                begin
                    best_found_reg <= 1'b1;
                end
                if (s2_valid_reg && s2_hit_reg && best_found_reg)
                begin
                    best_two_reg <= 1'b1;
                end
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (init_start)
        begin
            acc_reg <= '0;
        end
        else if (scan_start)
        begin
            acc_reg <= rl_ext;
        end
        else if ((state_reg == kwrm_pkg::ST_INIT) || s1_valid_reg)
        begin
            acc_reg <= acc_reg + rl_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == kwrm_pkg::ST_INIT)
        begin
            head_mem[idx_reg] <= acc_reg;
        end
        else if (out_load && best_found_reg)
        begin
            head_mem[best_idx_reg] <= best_head_reg + HW'(1);
        end
        if (issue_reg)
        begin
            head_q_reg <= head_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            store[count_reg[AW-1:0]] <= s_tdata;
        end
        if (s1_valid_reg)
        begin
            elem_q_reg <= store[head_q_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg     <= idx_reg;
        s1_last_reg    <= (idx_reg == LAST_RUN);
        s2_idx_reg     <= s1_idx_reg;
        s2_last_reg    <= s1_last_reg;
        s2_hit_reg     <= s1_hit;
        s2_next_ok_reg <= s1_next_ok;
        s2_head_reg    <= head_q_reg;
        if (take)
        begin
            best_val_reg     <= elem_q_reg;
            best_idx_reg     <= s2_idx_reg;
            best_head_reg    <= s2_head_reg;
            best_next_ok_reg <= s2_next_ok_reg;
        end
        if (out_load)
        begin
            m_data_reg  <= best_found_reg ? best_val_reg : '0;
            m_last_reg  <= best_found_reg && !best_two_reg && !best_next_ok_reg;
            m_empty_reg <= !best_found_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_empty_reg;

endmodule

`default_nettype wire

FILE: sv/kwrm_checker.sv
`default_nettype none

`include "k_way_run_merger_macros.svh"

module kwrm_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          cfg_wr_en,
    input wire [kwrm_pkg::RL_W-1:0]     cfg_wr_data,
    input wire                          s_tvalid,
    input wire                          s_tready,
    input wire [kwrm_pkg::VAL_W-1:0]    s_tdata,
    input wire [kwrm_pkg::OP_W-1:0]     s_tuser,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [kwrm_pkg::VAL_W-1:0]    m_tdata,
    input wire                          m_tlast,
    input wire [0:0]                    m_tuser
);

    `KWRM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result word changed while stalled")

    `KWRM_ASSERT_SAME(a_empty_clean, m_tvalid && m_tuser[0], (m_tdata == '0) && !m_tlast, "empty result carries data or last")

    `KWRM_ASSERT_NEXT(a_emit_busy, s_tvalid && s_tready && (s_tuser == kwrm_pkg::OP_EMIT), !s_tready, "input ready right after an emit word")

    `KWRM_ASSERT_NEXT(a_no_spurious, s_tvalid && s_tready && (s_tuser != kwrm_pkg::OP_EMIT) && !m_tvalid, !m_tvalid, "result appeared without an emit word")

endmodule

bind k_way_run_merger kwrm_checker u_kwrm_checker (.*);

`default_nettype wire

FILE: test/k_way_run_merger_checker.sv
module k_way_run_merger_checker #(
    parameter int DEPTH    = kwrm_pkg::DEPTH_DEF,
    parameter int MAX_RUNS = kwrm_pkg::MAX_RUNS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_wr_en,
    input  wire  [kwrm_pkg::RL_W-1:0]    cfg_wr_data,
    input  wire                          s_tvalid,
    input  wire                          s_tready,
    input  wire  [kwrm_pkg::VAL_W-1:0]   s_tdata,
    input  wire  [kwrm_pkg::OP_W-1:0]    s_tuser,
    input  wire                          m_tvalid,
    input  wire                          m_tready,
    input  wire  [kwrm_pkg::VAL_W-1:0]   m_tdata,
    input  wire                          m_tlast,
    input  wire  [0:0]                   m_tuser,
    output int                           mismatches,
    output int                           pending
);

    import kwrm_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic                    empty;
    } merge_out_t;

    logic signed [VAL_W-1:0] element_mem [DEPTH];
    int unsigned             fill_count;
    int unsigned             head_pos [MAX_RUNS];
    bit                      merging;
    logic [RL_W-1:0]         run_len;
    merge_out_t              awaiting [$];

    // A run length of zero behaves as one.
    function automatic int unsigned run_span();
        return (run_len == '0) ? 1 : run_len;
    endfunction

    function automatic int smallest_head_run();
        int          best;
        int unsigned bound;
        best = -1;
        for (int i = 0; i < MAX_RUNS; i++)
        begin
            bound = (i + 1) * run_span();
            if (bound > fill_count)
                bound = fill_count;
            if (head_pos[i] < bound &&
                (best < 0 || element_mem[head_pos[i]] < element_mem[head_pos[best]]))
                best = i;
        end
        return best;
    endfunction

    function automatic void apply_word(op_t op, logic [VAL_W-1:0] data);
        merge_out_t res;
        int         r;
        case (op)
            OP_LOAD:
            begin
                if (!merging && fill_count < DEPTH)
                begin
                    element_mem[fill_count] = data;
                    fill_count++;
                end
            end
            OP_CLEAR:
            begin
                fill_count = 0;
                merging = 1'b0;
            end
            OP_EMIT:
            begin
                if (!merging)
                begin
                    for (int i = 0; i < MAX_RUNS; i++)
                        head_pos[i] = i * run_span();
                    merging = 1'b1;
                end
                r = smallest_head_run();
                if (r < 0)
                    res = '{value: '0, last: 1'b0, empty: 1'b1};
                else
                begin
                    res.value = element_mem[head_pos[r]];
                    head_pos[r]++;
                    res.last = (smallest_head_run() < 0);
                    res.empty = 1'b0;
                end
                awaiting.push_back(res);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void report(string what, merge_out_t want, merge_out_t seen);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected value %0d last %0b empty %0b, got value %0d last %0b empty %0b",
                what, want.value, want.last, want.empty, seen.value, seen.last, seen.empty);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        merge_out_t seen;
        merge_out_t want;
        if (!rst_n)
        begin
            fill_count = 0;
            merging = 1'b0;
            run_len = RL_RESET;
            awaiting.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_wr_en)
                run_len = cfg_wr_data;
            if (m_tvalid && m_tready)
            begin
                seen = '{value: m_tdata, last: m_tlast, empty: m_tuser[0]};
                if (awaiting.size() == 0)
                    report("word with nothing expected", '0, seen);
                else
                begin
                    want = awaiting.pop_front();
                    if (seen.value !== want.value || seen.last !== want.last ||
                        seen.empty !== want.empty)
                        report("mismatch", want, seen);
                end
            end
            if (s_tvalid && s_tready)
                apply_word(op_t'(s_tuser), s_tdata);
        end
        pending = awaiting.size();
    end

endmodule

FILE: test/testbench.sv
module testbench;

    import kwrm_pkg::*;

    localparam int WORD_GOAL = 2000;
    localparam int PAUSE     = 2 * MAX_RUNS_DEF + 12;

    localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] INT_MIN = 32'sh8000_0000;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [RL_W-1:0]    cfg_wr_data;
    logic               s_tvalid;
    wire                s_tready;
    logic [VAL_W-1:0]   s_tdata;
    logic [OP_W-1:0]    s_tuser;
    wire                m_tvalid;
    logic               m_tready;
    wire  [VAL_W-1:0]   m_tdata;
    wire                m_tlast;
    wire  [0:0]         m_tuser;

    int mismatches;
    int pending;
    int words_sent;
    bit quiet_tail;
    bit hold_req;
    bit sender_bursty;
    bit merge_open;

    k_way_run_merger uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    k_way_run_merger_checker #(
        .DEPTH    (DEPTH_DEF),
        .MAX_RUNS (MAX_RUNS_DEF)
    ) merge_watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    // Output side: short stall bursts between runs of ready, one long hold on request.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(0, 30)) @(negedge clk);
            end
        end
    end

    // Called and returns at a falling edge.
    task automatic send_word(op_t op, logic [VAL_W-1:0] value, bit counted);
        int gap;
        if (!quiet_tail && sender_bursty && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if (counted)
            words_sent++;
        if (op == OP_EMIT)
            merge_open = 1'b1;
        else if (op == OP_CLEAR)
            merge_open = 1'b0;
    endtask

    task automatic load_word(logic [VAL_W-1:0] value);
        send_word(OP_LOAD, value, !merge_open);
    endtask

    task automatic drain_and_configure(logic [RL_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (PAUSE) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic signed [VAL_W-1:0] fresh_value(bit narrow);
        case ($urandom_range(0, 9))
            0: return INT_MIN;
            1: return INT_MAX;
            default: return narrow ? int'($urandom_range(0, 16)) - 8 : $urandom;
        endcase
    endfunction

    // Sorted runs of the given span with random content, or plain noise when unsorted.
    task automatic load_runs(int count, int unsigned span, bit sorted_runs, bit narrow);
        logic signed [VAL_W-1:0] v;
        int                      step;
        v = '0;
        for (int k = 0; k < count; k++)
        begin
            if (!sorted_runs || k % span == 0)
                v = fresh_value(narrow);
            else if (v <= INT_MAX - 3)
            begin
                step = narrow ? $urandom_range(0, 1) : $urandom_range(0, 3);
                v = v + step;
            end
            load_word(v);
        end
    endtask

    task automatic emit_words(int count, bit noisy);
        for (int k = 0; k < count; k++)
        begin
            send_word(OP_EMIT, $urandom, 1'b1);
            if (noisy && $urandom_range(0, 11) == 0)
                send_word($urandom_range(0, 1) ? OP_NONE : OP_LOAD, $urandom, 1'b0);
        end
    endtask

    initial
    begin
        logic [RL_W-1:0] run_reg;
        int unsigned     span;
        int              count;
        int              emits;
        int              limit;
        int              set_idx;

        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_NONE;
        hold_req = 1'b0;
        quiet_tail = 1'b0;
        sender_bursty = 1'b1;
        merge_open = 1'b0;
        words_sent = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: emit on an empty store, extreme values, ties between runs,
        // a short last run, an unused opcode, a load during the merge, clear.
        drain_and_configure(11'd3);
        send_word(OP_EMIT, '0, 1'b1);
        send_word(OP_CLEAR, '0, 1'b1);
        load_word(INT_MIN);
        load_word(32'sd0);
        load_word(INT_MAX);
        load_word(-32'sd1);
        load_word(32'sd0);
        load_word(INT_MAX);
        load_word(32'sd0);
        send_word(OP_NONE, 32'hFFFF_FFFF, 1'b0);
        emit_words(4, 1'b0);
        send_word(OP_LOAD, 32'h5A5A_5A5A, 1'b0);
        emit_words(4, 1'b0);
        send_word(OP_CLEAR, 32'hA5A5_A5A5, 1'b1);
        send_word(OP_EMIT, '0, 1'b1);

        run_reg = 11'd3;
        set_idx = 0;
        while (words_sent < WORD_GOAL)
        begin
            if (words_sent >= WORD_GOAL - 300)
                quiet_tail = 1'b1;
            sender_bursty = ($urandom_range(0, 3) != 0);
            if (set_idx == 0)
                drain_and_configure(11'd0);
            else if (set_idx == 4)
                drain_and_configure(11'd128);
            else if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 15))
                    0: drain_and_configure(11'd1024);
                    1: drain_and_configure(11'd2047);
                    2: drain_and_configure(11'd1);
                    3: drain_and_configure(11'd0);
                    default: drain_and_configure(RL_W'($urandom_range(1, 9)));
                endcase
            end
            run_reg = cfg_wr_data;
            span = (run_reg == '0) ? 1 : run_reg;

            if (set_idx == 4)
            begin
                // Full store with two loads past the end, then a long output stall.
                send_word(OP_CLEAR, $urandom, 1'b1);
                load_runs(DEPTH_DEF + 2, span, 1'b1, 1'b0);
                hold_req = 1'b1;
                emit_words(40, 1'b1);
            end
            else
            begin
                if (set_idx == 0 || $urandom_range(0, 6) != 0)
                    send_word(OP_CLEAR, $urandom, 1'b1);
                limit = (span * (MAX_RUNS_DEF + 1) < 48) ? span * (MAX_RUNS_DEF + 1) : 48;
                count = (set_idx == 0) ? MAX_RUNS_DEF + 3 : $urandom_range(0, limit);
                load_runs(count, span, $urandom_range(0, 9) != 0, $urandom_range(0, 1));
                if ($urandom_range(0, 4) == 0)
                    emits = $urandom_range(0, count);
                else
                    emits = count + $urandom_range(0, 2);
                emit_words(emits, 1'b1);
            end
            set_idx++;
        end

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (PAUSE) @(negedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: k_way_run_merger.f
+incdir+sv
sv/kwrm_pkg.sv
sv/k_way_run_merger.sv
sv/kwrm_checker.sv
test/k_way_run_merger_checker.sv
test/testbench.sv
